[hdl/tcps_pkg.sv]
// Shared types and constants for the telemetry command and period scheduler.
// No dependencies; compiled first.
package tcps_pkg;

  localparam int NUM_STREAMS_DEF = 3;
  localparam int NUM_STREAMS_MAX = 8;

  localparam logic [7:0] SEL_MASK     = 8'h1F;
  localparam logic [7:0] PERIOD_RESET = 8'd100;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_DONE     = 3'd1;
  localparam logic [2:0] EV_OVERFLOW = 3'd2;
  localparam logic [2:0] EV_ERROR    = 3'd3;
  localparam logic [2:0] EV_LETTER   = 3'd4;
  localparam logic [2:0] EV_DUE      = 3'd5;

  localparam logic [1:0] SC_ERROR  = 2'd0;
  localparam logic [1:0] SC_ENABLE = 2'd1;
  localparam logic [1:0] SC_PERIOD = 2'd2;
  localparam logic [1:0] SC_LETTER = 2'd3;
  localparam logic [7:0] SC_LAST   = 8'd3;

  localparam logic REG_END_MARKER    = 1'b0;
  localparam logic REG_MODULE_LETTER = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] elapsed;
    logic [7:0] error_code;
    logic [7:0] error_edge;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] due_mask;
    logic [7:0] report_first;
    logic [7:0] report_second;
  } out_item_t;

  typedef struct packed {
    logic       addr;
    logic [7:0] wdata;
  } cfg_item_t;

endpackage

[hdl/tcps_chan_if.sv]
// Valid/ready channel carrying one payload per transfer.
// Payload type is a parameter; no package dependency.
interface tcps_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/telemetry_command_and_period_scheduler.sv]
// Telemetry command decoder and period scheduler, top level.
// Depends on tcps_pkg and tcps_chan_if.
// Command byte: S_EMIT sends the result, waiting on an unaccepted one; S_IDLE takes the next.
// Tick: one shared add/compare/subtract unit, one S_LOAD pass per stream plus 8 remainder steps
// in S_DIV per stream firing on a nonzero period, then the result goes out through S_EMIT.
// Reset (rst, synchronous): periods 100, accumulators, enables and registers zero.
module telemetry_command_and_period_scheduler #(
  parameter int NUM_STREAMS = tcps_pkg::NUM_STREAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tcps_chan_if.sink   cmd,
  tcps_chan_if.source rsp,
  tcps_chan_if.sink   cfg
);
  import tcps_pkg::*;

  localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int MW    = (NUM_STREAMS > 3) ? NUM_STREAMS : 3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STREAMS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]             state;
  logic [7:0]             end_marker;
  logic [7:0]             module_letter;
  logic                   awaiting;
  logic [1:0]             subc;
  logic [1:0]             fbc;
  logic [NUM_STREAMS-1:0] pflags;
  logic [NUM_STREAMS-1:0] ptarget;
  logic [7:0]             pperiod;
  logic [NUM_STREAMS-1:0] en;
  logic [7:0]             per [NUM_STREAMS];
  logic [7:0]             acc [NUM_STREAMS];
  logic [IDX_W-1:0]       idx;
  logic [7:0]             el;
  logic [NUM_STREAMS-1:0] mask;
  logic [7:0]             dvd;
  logic [7:0]             rem;
  logic [2:0]             bitcnt;
  out_item_t              rd;
  logic                   ov;
  out_item_t              od;

  logic                   cmd_xfer;
  logic                   closing;
  logic [7:0]             sel;
  logic                   tgt_hit;
  logic [IDX_W-1:0]       tgt_idx;
  logic [7:0]             cur_p;
  logic [7:0]             sum;
  logic                   fire;
  logic [8:0]             trial;
  logic                   trial_ge;
  logic [7:0]             rem_next;
  logic [NUM_STREAMS-1:0] mask_next;
  logic [MW-1:0]          mask_ext;
  logic                   stream_done;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = ov;
  assign rsp.data  = od;

  assign cmd_xfer = cmd.valid && cmd.ready;
  assign closing  = (cmd.data.rx_byte == end_marker);
  assign sel      = cmd.data.rx_byte & SEL_MASK;

  always_comb begin
    tgt_hit = 1'b0;
    tgt_idx = '0;
    for (int i = NUM_STREAMS - 1; i >= 0; i--) begin
      if (ptarget[i]) begin
        tgt_hit = 1'b1;
        tgt_idx = IDX_W'(i);
      end
    end
  end

  // Shared unit: add/compare in S_LOAD, one remainder step in S_DIV.
  always_comb begin
    cur_p    = per[idx];
    sum      = en[idx] ? (acc[idx] + el) : acc[idx];
    fire     = (sum >= cur_p);
    trial    = {rem, dvd[7]};
    trial_ge = (trial >= {1'b0, cur_p});
    rem_next = trial_ge ? 8'(trial - {1'b0, cur_p}) : trial[7:0];
    mask_next = mask;
    if (state == S_LOAD && fire) begin
      mask_next[idx] = 1'b1;
    end
    mask_ext = MW'(mask_next);
    stream_done = (state == S_LOAD && (!fire || cur_p == 8'd0)) ||
                  (state == S_DIV && bitcnt == 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker    <= '0;
      module_letter <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.addr)
        REG_END_MARKER:    end_marker    <= cfg.data.wdata;
        REG_MODULE_LETTER: module_letter <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      awaiting <= 1'b1;
      subc     <= '0;
      fbc      <= '0;
      pflags   <= '0;
      ptarget  <= '0;
      pperiod  <= '0;
      en       <= '0;
      idx      <= '0;
      mask     <= '0;
      bitcnt   <= '0;
      ov       <= 1'b0;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        per[i] <= PERIOD_RESET;
        acc[i] <= '0;
      end
    end else begin
      if (rsp.valid && rsp.ready && state != S_EMIT) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            if (cmd.data.action) begin
              el    <= cmd.data.elapsed;
              idx   <= '0;
              mask  <= '0;
              state <= S_LOAD;
            end else if (awaiting) begin
              state <= S_EMIT;
              fbc   <= '0;
              if (sel > SC_LAST) begin
                rd <= '{EV_OVERFLOW, 3'd0, 8'd0, 8'd0};
              end else begin
                rd       <= '{EV_NONE, 3'd0, 8'd0, 8'd0};
                subc     <= sel[1:0];
                awaiting <= 1'b0;
              end
            end else begin
              state <= S_EMIT;
              case (subc)
                SC_ERROR: begin
                  if (closing) begin
                    rd <= '{EV_ERROR, 3'd0, cmd.data.error_code, cmd.data.error_edge};
                  end else begin
                    rd <= '{EV_OVERFLOW, 3'd0, 8'd0, 8'd0};
                  end
                  awaiting <= 1'b1;
                  fbc      <= '0;
                end
                SC_ENABLE: begin
                  if (fbc == 2'd0) begin
                    rd     <= '{EV_NONE, 3'd0, 8'd0, 8'd0};
                    pflags <= cmd.data.rx_byte[NUM_STREAMS-1:0];
                    fbc    <= 2'd1;
                  end else begin
                    if (closing) begin
                      en <= pflags;
                      rd <= '{EV_DONE, 3'd0, 8'd0, 8'd0};
                    end else begin
                      rd <= '{EV_OVERFLOW, 3'd0, 8'd0, 8'd0};
                    end
                    awaiting <= 1'b1;
                    fbc      <= '0;
                  end
                end
                SC_PERIOD: begin
                  if (fbc == 2'd0) begin
                    rd      <= '{EV_NONE, 3'd0, 8'd0, 8'd0};
                    ptarget <= cmd.data.rx_byte[NUM_STREAMS-1:0];
                    fbc     <= 2'd1;
                  end else if (fbc == 2'd1) begin
                    rd      <= '{EV_NONE, 3'd0, 8'd0, 8'd0};
                    pperiod <= cmd.data.rx_byte;
                    fbc     <= 2'd2;
                  end else begin
                    if (closing) begin
                      for (int i = 0; i < NUM_STREAMS; i++) begin
                        if (!tgt_hit || tgt_idx == IDX_W'(i)) begin
                          per[i] <= pperiod;
                        end
                      end
                      rd <= '{EV_DONE, 3'd0, 8'd0, 8'd0};
                    end else begin
                      rd <= '{EV_OVERFLOW, 3'd0, 8'd0, 8'd0};
                    end
                    ptarget  <= '0;
                    awaiting <= 1'b1;
                    fbc      <= '0;
                  end
                end
                SC_LETTER: begin
                  if (closing) begin
                    rd <= '{EV_LETTER, 3'd0, module_letter, 8'd0};
                  end else begin
                    rd <= '{EV_OVERFLOW, 3'd0, 8'd0, 8'd0};
                  end
                  awaiting <= 1'b1;
                  fbc      <= '0;
                end
                default: begin
                  rd       <= '{EV_OVERFLOW, 3'd0, 8'd0, 8'd0};
                  awaiting <= 1'b1;
                  fbc      <= '0;
                end
              endcase
            end
          end
        end
        S_LOAD: begin
          mask <= mask_next;
          if (!fire) begin
            acc[idx] <= sum;
          end else if (cur_p == 8'd0) begin
            acc[idx] <= '0;
          end else begin
            dvd    <= sum;
            rem    <= '0;
            bitcnt <= 3'd7;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= rem_next;
          dvd    <= {dvd[6:0], 1'b0};
          bitcnt <= bitcnt - 3'd1;
          if (bitcnt == 3'd0) begin
            acc[idx] <= rem_next;
          end
        end
        S_EMIT: begin
          if (!ov || rsp.ready) begin
            od    <= rd;
            ov    <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (stream_done) begin
        if (idx == LAST_IDX) begin
          rd    <= '{(mask_next != '0) ? EV_DUE : EV_NONE, mask_ext[2:0], 8'd0, 8'd0};
          state <= S_EMIT;
        end else begin
          idx   <= idx + IDX_W'(1);
          state <= S_LOAD;
        end
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_tick_load: assert property (@(posedge clk) disable iff (rst)
    (cmd_xfer && cmd.data.action) |=> state == S_LOAD) else $error("tick not started");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < cur_p) else $error("remainder out of range");
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.data.event_res <= EV_DUE) else $error("bad event code");
  a_due_only: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.event_res != EV_DUE) |-> rsp.data.due_mask == 3'd0)
    else $error("due mask outside due event");

endmodule
